>>> rtl/core/ordered_list_append_delete_defines.svh
// Assertion macros for the ordered list append/delete block.
// Used by the top level; depends on signals named clk and arst_n in the includer.
`ifndef ORDERED_LIST_APPEND_DELETE_DEFINES_SVH
`define ORDERED_LIST_APPEND_DELETE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define OLAD_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("olad assertion failed");
// Check that a trigger at one edge implies a condition at the next edge.
`define OLAD_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("olad assertion failed");
`else
`define OLAD_ASSERT_ALWAYS(label, cond)
`define OLAD_ASSERT_NEXT(label, trig, cond)
`endif

`endif

>>> rtl/core/olad_pkg.sv
// Shared types and codes for the ordered list append/delete block.
// No dependencies.
package olad_pkg;

	localparam int VAL_W = 32;
	localparam int LEN_W = 5;

	// Command codes (carried on s_tuser)
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	// Result status codes (carried on m_tuser)
	localparam logic [1:0] ST_APPENDED  = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_DELETED   = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// Per-cell control for one beat
	typedef struct packed {
		logic load;   // write the incoming value (append at tail)
		logic shift;  // take the neighbor's entry (close a gap)
	} cell_ctrl_t;

endpackage

>>> rtl/core/ordered_list_append_delete.sv
// Top level of the ordered list append/delete block: cell row, match locator, result register.
// Depends on olad_pkg, olad_cell, olad_find and ordered_list_append_delete_defines.svh.
//
//  channel  | dir | tdata                      | tuser
//  ---------+-----+----------------------------+------------------------
//  s_*      | in  | [31:0] value (signed)      | [0] cmd (0 append, 1 delete)
//  m_*      | out | [4:0] list_length, [7:5] 0 | [1:0] status
//
// One command per cycle: every cell compares its entry with the value in the same
// cycle, a log-depth prefix OR picks the first match, and the cells shift to close
// the gap on the next edge. The result sits in an output register; a new command is
// taken while that register is empty or being drained. Reset clears the length and
// the output valid; cell contents are left as they are and are never read unoccupied.
`include "ordered_list_append_delete_defines.svh"

module ordered_list_append_delete import olad_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [4:0] list_length, [7:5] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_next;
	logic                    out_valid_q;
	logic [1:0]              status_q;
	logic [LEN_W-1:0]        len_q;
	logic [1:0]              status_next;
	logic [CNT_W+LEN_W-1:0]  len_ext;
	logic                    in_acc;
	logic                    do_append;
	logic                    do_delete;
	logic                    is_full;
	logic signed [VAL_W-1:0] value;
	logic [CAPACITY-1:0]     occ;
	logic [CAPACITY-1:0]     match;
	logic [CAPACITY-1:0]     hit_at;
	logic                    hit_any;
	logic signed [VAL_W-1:0] cell_data [CAPACITY];
	cell_ctrl_t              cell_ctrl [CAPACITY];

	// Accept a beat while the result register is free or draining
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign value    = s_tdata;
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign do_append = in_acc && (s_tuser == CMD_APPEND) && !is_full;
	assign do_delete = in_acc && (s_tuser == CMD_DELETE) && hit_any;

	// Build the cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);
		assign cell_ctrl[i].load  = do_append && (count_q == CNT_W'(i));
		assign cell_ctrl[i].shift = do_delete && hit_at[i];

		if (i < CAPACITY - 1) begin : g_mid
			olad_cell u_cell (
				.clk       (clk),
				.ctrl      (cell_ctrl[i]),
				.value_in  (value),
				.next_data (cell_data[i+1]),
				.occupied  (occ[i]),
				.data      (cell_data[i]),
				.match     (match[i])
			);
		end else begin : g_last
			olad_cell u_cell (
				.clk       (clk),
				.ctrl      (cell_ctrl[i]),
				.value_in  (value),
				.next_data (cell_data[i]),
				.occupied  (occ[i]),
				.data      (cell_data[i]),
				.match     (match[i])
			);
		end
	end

	// Locate the match nearest the head
	olad_find #(.N(CAPACITY)) u_find (
		.match       (match),
		.at_or_after (hit_at),
		.any         (hit_any)
	);

	// Next length and status for the accepted beat
	always_comb begin
		count_next  = count_q;
		status_next = ST_NOT_FOUND;
		if (s_tuser == CMD_APPEND) begin
			if (is_full) begin
				status_next = ST_FULL;
			end else begin
				status_next = ST_APPENDED;
				count_next  = count_q + CNT_W'(1);
			end
		end else if (hit_any) begin
			status_next = ST_DELETED;
			count_next  = count_q - CNT_W'(1);
		end
	end

	assign len_ext = {{LEN_W{1'b0}}, count_next};

	// Advance length and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold result payload until the next accepted beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= status_next;
			len_q    <= len_ext[LEN_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {{(8-LEN_W){1'b0}}, len_q};

	`OLAD_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY))
	`OLAD_ASSERT_NEXT(a_full_holds, do_append && count_q == CNT_W'(CAPACITY - 1), count_q == CNT_W'(CAPACITY))
	`OLAD_ASSERT_NEXT(a_delete_shrinks, do_delete, count_q == $past(count_q) - CNT_W'(1))
	`OLAD_ASSERT_ALWAYS(a_hit_in_list, !hit_any || (count_q != '0))

endmodule

>>> rtl/core/olad_cell.sv
// One list cell: holds a single entry and compares it with the command value.
// Depends on olad_pkg.
module olad_cell import olad_pkg::*; (
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic signed [VAL_W-1:0] value_in,
	input  logic signed [VAL_W-1:0] next_data,
	input  logic                    occupied,
	output logic signed [VAL_W-1:0] data,
	output logic                    match
);

	logic signed [VAL_W-1:0] data_q;

	// Load on append, take the neighbor's entry on a delete shift, else hold
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= value_in;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	// Only occupied cells may report a match
	assign match = occupied && (data_q == value_in);
	assign data  = data_q;

endmodule

>>> rtl/core/olad_find.sv
// First-match locator: inclusive prefix OR of the cell match vector.
// No package dependencies; log-depth OR network.
module olad_find #(
	parameter int N = 16
) (
	input  logic [N-1:0] match,
	output logic [N-1:0] at_or_after,
	output logic         any
);

	localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] p;

	// Spread each match toward the tail in doubling strides
	always_comb begin
		p = match;
		for (int k = 0; k < LEVELS; k++) begin
			p = p | (p << (1 << k));
		end
	end

	assign at_or_after = p;
	assign any         = p[N-1];

endmodule
